// ===== hdl/mtstk_pkg.sv =====
// Package for the min-tracking stack: sequencer states and error codes.
package mtstk_pkg;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } mtstk_state_t;

  // Request modes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

endpackage

// ===== hdl/min_tracking_stack.sv =====
// Top level of the min-tracking stack: stack plus running-minimum stack in two RAMs.
//
// A request is taken when start is high and busy is low. Its result shows on
// the result ports for exactly one cycle, marked by done. For a push or a
// failed request that cycle follows the one in which the request was taken;
// for a successful pop it follows the ST_READ state. The receiver cannot stall
// the block. A push, or any request that fails (pop on empty, push on full),
// leaves busy low, so such requests can be issued every cycle. A successful
// pop fetches the new top and the new minimum from the value RAM and the
// minima RAM, whose read data are registered, and busy is high during that
// fetch. The current top and minimum are kept in registers, so a push needs
// no read. Top and minimum read 0 when the stack is empty.
module min_tracking_stack #(
  parameter int STACK_DEPTH = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [31:0] push_value,
  output logic        done,
  output logic [31:0] popped_value,
  output logic [31:0] top_value,
  output logic [31:0] min_value,
  output logic [8:0]  element_count,
  output logic        is_empty,
  output logic [1:0]  error_code
);

  import mtstk_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int VW = VALUE_WIDTH;

  mtstk_state_t state, state_next;

  logic [CW-1:0] cnt;
  logic [CW-1:0] mcnt;
  logic [VW-1:0] top_reg;
  logic [VW-1:0] min_reg;
  logic [VW-1:0] popped_reg;
  logic [1:0]    err_reg;
  logic          pop_drop;

  logic          accept;
  logic [VW-1:0] push_v;
  logic          take;
  logic [CW-1:0] cnt_m2;
  logic [CW-1:0] mcnt_m2;
  logic          val_we;
  logic          min_we;
  logic [VW-1:0] val_rdata;
  logic [VW-1:0] min_rdata;

  // Fit the 32-bit request value to the stored width, sign-extended
  logic [VW+31:0] push_ext;
  assign push_ext = {{VW{push_value[31]}}, push_value};
  assign push_v   = push_ext[VW-1:0];

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Minimum tracking: take on empty minima or value at most the current minimum
  assign take = (mcnt == '0) || ($signed(push_v) <= $signed(min_reg));

  assign val_we = accept && (mode == MODE_PUSH) && (cnt != CW'(STACK_DEPTH));
  assign min_we = val_we && take;

  // Addresses of the entries below the current tops, fetched on a pop
  assign cnt_m2  = cnt - CW'(2);
  assign mcnt_m2 = mcnt - CW'(2);

  mtstk_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (cnt[AW-1:0]),
    .wdata (push_v),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (val_rdata)
  );

  mtstk_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_minima_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (mcnt[AW-1:0]),
    .wdata (push_v),
    .raddr (mcnt_m2[AW-1:0]),
    .rdata (min_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a successful pop goes to ST_READ to wait for RAM read data
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_POP) && (cnt != '0)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Counts and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      mcnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        if (mode == MODE_PUSH) begin
          done <= 1'b1;
          if (cnt != CW'(STACK_DEPTH)) begin
            cnt <= cnt + CW'(1);
            if (take) begin
              mcnt <= mcnt + CW'(1);
            end
          end
        end else if (cnt == '0) begin
          done <= 1'b1;
        end else begin
          cnt <= cnt - CW'(1);
          if ((mcnt != '0) && (min_reg == top_reg)) begin
            mcnt <= mcnt - CW'(1);
          end
        end
      end else if (state == ST_READ) begin
        done <= 1'b1;
      end
    end
  end

  // Top and minimum registers, popped value and error code
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_reg <= '0;
      err_reg    <= ERR_NONE;
      pop_drop   <= 1'b0;
      if (mode == MODE_PUSH) begin
        if (cnt == CW'(STACK_DEPTH)) begin
          err_reg <= ERR_FULL;
        end else begin
          top_reg <= push_v;
          if (take) begin
            min_reg <= push_v;
          end
        end
      end else if (cnt == '0) begin
        err_reg <= ERR_EMPTY;
      end else begin
        popped_reg <= top_reg;
        pop_drop   <= (mcnt != '0) && (min_reg == top_reg);
      end
    end else if (state == ST_READ) begin
      top_reg <= val_rdata;
      if (pop_drop) begin
        min_reg <= min_rdata;
      end
    end
  end

  // Result ports, sign-extended or cut to 32 bits; the count zero-extended or cut to 9 bits
  logic [VW+31:0] popped_ext;
  logic [VW+31:0] top_ext;
  logic [VW+31:0] min_ext;
  logic [CW+8:0]  cnt_ext;

  assign popped_ext = {{32{popped_reg[VW-1]}}, popped_reg};
  assign top_ext    = {{32{top_reg[VW-1]}}, top_reg};
  assign min_ext    = {{32{min_reg[VW-1]}}, min_reg};
  assign cnt_ext    = {9'b0, cnt};

  assign popped_value  = popped_ext[31:0];
  assign top_value     = (cnt != '0) ? top_ext[31:0] : 32'd0;
  assign min_value     = ((cnt != '0) && (mcnt != '0)) ? min_ext[31:0] : 32'd0;
  assign element_count = cnt_ext[8:0];
  assign is_empty      = (cnt == '0);
  assign error_code    = err_reg;

`ifndef SYNTHESIS
  // A taken push or failed request yields done, and the pop fetch state ends with done and a return to idle
  a_push_done: assert property (@(posedge clk) disable iff (rst)
    accept && ((mode == MODE_PUSH) || (cnt == '0)) |=> done)
    else $error("push or failed request gave no result");

  a_pop_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> done && (state == ST_IDLE))
    else $error("pop fetch did not finish in one cycle");

  a_min_le_cnt: assert property (@(posedge clk) disable iff (rst)
    mcnt <= cnt)
    else $error("minima count exceeds element count");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("element count beyond depth");

  a_nonempty_min: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> (mcnt != '0))
    else $error("nonempty stack with no minimum");
`endif

endmodule

// ===== hdl/mtstk_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mtstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== test/mtstk_checker.sv =====
// Checker for the min-tracking stack: predicts each result and compares it with the block's.
module mtstk_checker #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        mode,
  input  logic [31:0] push_value,
  input  logic        done,
  input  logic [31:0] popped_value,
  input  logic [31:0] top_value,
  input  logic [31:0] min_value,
  input  logic [8:0]  element_count,
  input  logic        is_empty,
  input  logic [1:0]  error_code,
  output int          errors,
  output int          pending
);

  import mtstk_pkg::*;

  typedef struct packed {
    logic [31:0] popped;
    logic [31:0] top;
    logic [31:0] minv;
    logic [8:0]  count;
    logic        empty;
    logic [1:0]  err;
  } stack_result_t;

  // Shadow copy of both stacks
  logic signed [31:0] shadow_values [DEPTH];
  logic signed [31:0] shadow_minima [DEPTH];
  int unsigned        n_values;
  int unsigned        n_minima;

  stack_result_t expected_results [$];
  int            fail_total;

  initial begin
    errors     = 0;
    pending    = 0;
    fail_total = 0;
    n_values   = 0;
    n_minima   = 0;
  end

  // Apply one request to the shadow stacks and return what the block should report
  function automatic stack_result_t apply_request(logic op, logic signed [31:0] v);
    stack_result_t      r;
    logic signed [31:0] t;
    r     = '0;
    r.err = ERR_NONE;
    if (op == MODE_PUSH) begin
      if (n_values >= DEPTH) begin
        r.err = ERR_FULL;
      end else begin
        shadow_values[n_values] = v;
        n_values++;
        // ties also go on the minima stack so duplicates pop correctly
        if (n_minima == 0 || v <= shadow_minima[n_minima - 1]) begin
          shadow_minima[n_minima] = v;
          n_minima++;
        end
      end
    end else if (n_values == 0) begin
      r.err = ERR_EMPTY;
    end else begin
      t = shadow_values[n_values - 1];
      if (n_minima > 0 && shadow_minima[n_minima - 1] == t) begin
        n_minima--;
      end
      n_values--;
      r.popped = t;
    end
    if (n_values > 0) begin
      r.top = shadow_values[n_values - 1];
      if (n_minima > 0) begin
        r.minv = shadow_minima[n_minima - 1];
      end
    end
    r.count = n_values[8:0];
    r.empty = (n_values == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_total++;
      $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, name, want, got);
    end
  endtask

  // Predict on each accepted request, compare on each done strobe
  always @(posedge clk) begin
    stack_result_t want;
    if (rst) begin
      n_values = 0;
      n_minima = 0;
      expected_results.delete();
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_request(mode, push_value));
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          fail_total++;
          $display("%0t: result strobe with no request outstanding", $time);
        end else begin
          want = expected_results.pop_front();
          check_field("popped_value", want.popped, popped_value);
          check_field("top_value", want.top, top_value);
          check_field("min_value", want.minv, min_value);
          check_field("element_count", 32'(want.count), 32'(element_count));
          check_field("is_empty", 32'(want.empty), 32'(is_empty));
          check_field("error_code", 32'(want.err), 32'(error_code));
        end
      end
    end
    errors  <= fail_total;
    pending <= expected_results.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the min-tracking stack testbench: clock, reset, request stimulus and verdict.
module testbench;
  import mtstk_pkg::*;

  localparam int DEPTH       = 256;
  localparam int ITEMS       = 1500;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        mode = MODE_PUSH;
  logic [31:0] push_value = '0;
  logic        busy;
  logic        done;
  logic [31:0] popped_value;
  logic [31:0] top_value;
  logic [31:0] min_value;
  logic [8:0]  element_count;
  logic        is_empty;
  logic [1:0]  error_code;
  int          errors;
  int          pending;

  // Stimulus-side bookkeeping
  int depth_now = 0;
  int peak_depth = 0;
  int issued = 0;
  int n_pushes = 0;
  int n_pops = 0;
  int n_full = 0;
  int n_empty = 0;
  int burst_left = 0;
  int cycles = 0;

  min_tracking_stack #(
    .STACK_DEPTH(DEPTH),
    .VALUE_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .push_value(push_value),
    .done(done),
    .popped_value(popped_value),
    .top_value(top_value),
    .min_value(min_value),
    .element_count(element_count),
    .is_empty(is_empty),
    .error_code(error_code)
  );

  mtstk_checker #(
    .DEPTH(DEPTH)
  ) chk (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .push_value(push_value),
    .done(done),
    .popped_value(popped_value),
    .top_value(top_value),
    .min_value(min_value),
    .element_count(element_count),
    .is_empty(is_empty),
    .error_code(error_code),
    .errors(errors),
    .pending(pending)
  );

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Value styles: 0 narrow (many ties), 1 full range, 2 extremes, else mixed
  function automatic logic [31:0] pick_value(int style);
    int s;
    s = (style > 2) ? $urandom_range(0, 2) : style;
    case (s)
      0: return 32'($signed($urandom_range(0, 8)) - 4);
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
    endcase
  endfunction

  // Issue one request; bursts with random gaps, random junk on the inputs while idle
  task automatic issue(logic op, logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) begin
          mode       <= 1'($urandom);
          push_value <= $urandom;
          @(posedge clk);
        end
      end
    end
    burst_left--;
    start      <= 1'b1;
    mode       <= op;
    push_value <= v;
    do @(posedge clk); while (busy);
    issued++;
    if (op == MODE_PUSH) begin
      n_pushes++;
      if (depth_now < DEPTH) depth_now++;
      else n_full++;
    end else begin
      n_pops++;
      if (depth_now > 0) depth_now--;
      else n_empty++;
    end
    if (depth_now > peak_depth) peak_depth = depth_now;
  endtask

  initial begin
    int  walk_len;
    int  push_pct;
    int  style;
    bit  filled;
    filled = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: pop on empty, sign extremes, tied minima, drain past empty
    issue(MODE_POP, 32'hdead_beef);
    issue(MODE_PUSH, 32'h0000_0000);
    issue(MODE_POP, 32'h0);
    issue(MODE_POP, 32'hffff_ffff);
    issue(MODE_PUSH, 32'h7fff_ffff);
    issue(MODE_PUSH, 32'h8000_0000);
    issue(MODE_PUSH, 32'h8000_0000);
    issue(MODE_PUSH, 32'hffff_ffff);
    issue(MODE_PUSH, 32'h8000_0000);
    issue(MODE_POP, 32'h0);
    issue(MODE_POP, 32'h0);
    issue(MODE_POP, 32'h0);
    issue(MODE_POP, 32'h0);
    issue(MODE_PUSH, 32'd5);
    issue(MODE_PUSH, 32'd5);
    issue(MODE_PUSH, 32'd4);
    issue(MODE_POP, 32'h0);
    issue(MODE_POP, 32'h0);
    issue(MODE_POP, 32'h0);
    issue(MODE_POP, 32'h0);
    issue(MODE_POP, 32'h0);

    // Random walks, with one pass that fills to full, overfills, then drains past empty
    while (issued < ITEMS) begin
      if (!filled && issued > 300) begin
        while (depth_now < DEPTH) issue(MODE_PUSH, pick_value(3));
        repeat (3) issue(MODE_PUSH, pick_value(3));
        while (depth_now > 0) issue(MODE_POP, $urandom);
        repeat (2) issue(MODE_POP, $urandom);
        filled = 1;
      end else begin
        walk_len = $urandom_range(20, 80);
        push_pct = $urandom_range(35, 70);
        style    = $urandom_range(0, 3);
        repeat (walk_len) begin
          if ($urandom_range(0, 99) < push_pct) issue(MODE_PUSH, pick_value(style));
          else issue(MODE_POP, $urandom);
        end
      end
    end

    // Drain outstanding results
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d requests: %0d pushes, %0d pops, peak depth %0d of %0d.",
             issued, n_pushes, n_pops, peak_depth, DEPTH);
    $display("Rejected: %0d pushes on full, %0d pops on empty.", n_full, n_empty);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
